// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the search block
// expects clk and arst_n in the scope of the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every edge outside reset
`define FSMS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("search block assertion failed");

// overlapping implication
`define FSMS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("search block assertion failed");

// next-cycle implication
`define FSMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("search block assertion failed");

`endif

// ----- rtl/core/fsms_pkg.sv -----
// types and fixed widths for the first substring match search block
// used by fsms_cell and first_substring_match_search
package fsms_pkg;

	localparam int SYM_W = 8;
	localparam int POS_W = 24;

	typedef logic [SYM_W-1:0] sym_t;

	typedef struct packed {
		logic load;   // take a pattern symbol from the left neighbor
		logic shift;  // take a reference symbol from the left neighbor
		logic clear;  // drop the reference window
	} cell_ctrl_t;

endpackage

// ----- rtl/core/fsms_cell.sv -----
// one cell of the compare chain: a pattern symbol, a reference symbol and flags
// depends on fsms_pkg
module fsms_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fsms_pkg::cell_ctrl_t   ctrl,
	input  fsms_pkg::sym_t         pat_in,
	input  logic                   act_in,
	input  fsms_pkg::sym_t         ref_in,
	input  logic                   rv_in,
	output fsms_pkg::sym_t         pat_out,
	output logic                   act_out,
	output fsms_pkg::sym_t         ref_out,
	output logic                   rv_out,
	output logic                   hit
);

	fsms_pkg::sym_t pat_q;
	fsms_pkg::sym_t ref_q;
	logic           act_q;
	logic           rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			rv_q  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				act_q <= act_in;
			end
			if (ctrl.clear) begin
				rv_q <= 1'b0;
			end else if (ctrl.shift) begin
				rv_q <= rv_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pat_q <= pat_in;
		end
		if (ctrl.shift) begin
			ref_q <= ref_in;
		end
	end

	// compare against the symbol about to enter this cell
	assign hit     = !act_q || (rv_in && (ref_in == pat_q));
	assign pat_out = pat_q;
	assign act_out = act_q;
	assign ref_out = ref_q;
	assign rv_out  = rv_q;

endmodule

// ----- rtl/core/first_substring_match_search.sv -----
// Finds the first place where a loaded byte pattern occurs in a streamed reference.
// Words with tuser[0]=0 load pattern symbols (tuser[1] restarts the pattern); words
// with tuser[0]=1 are reference symbols, and tlast marks the end of a reference.
// One result word comes at the first full match (found=1, start position), or on
// the last reference symbol if nothing matched (found=0, position 0). The block
// takes one word every cycle: a row of PATTERN_MAX cells holds the pattern and the
// newest reference symbols, and every cell compares its incoming symbol in the
// cycle the word is accepted, so the result sits in the output register in the next
// cycle. Input is taken whenever that register is empty or being emptied.
// Depends on fsms_pkg, fsms_cell and assert_macros.svh.
module first_substring_match_search #(
	parameter int PATTERN_MAX   = 64,
	parameter int POSITION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // symbol
	input  logic [1:0]  s_tuser,   // req_type, first_of_pattern
	input  logic        s_tlast,   // last_of_reference
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // position
	output logic        m_tuser    // found
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CW    = (POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W;
	localparam int OW    = fsms_pkg::POS_W;

	logic                     acc;
	logic                     is_pat;
	logic                     is_ref;
	logic                     first;
	logic                     last;
	fsms_pkg::cell_ctrl_t     ctrl;

	fsms_pkg::sym_t           pat_chain [PATTERN_MAX];
	fsms_pkg::sym_t           ref_chain [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]   act_chain;
	logic [PATTERN_MAX-1:0]   rv_chain;
	logic [PATTERN_MAX-1:0]   hits;

	logic [LEN_W-1:0]         len_q;
	logic [POSITION_BITS-1:0] seen_q;
	logic [POSITION_BITS-1:0] seen_nxt;
	logic                     reported_q;
	logic                     match;
	logic                     res_found;
	logic                     res_none;
	logic [CW-1:0]            start;
	logic [OW+CW-1:0]         start_ext;

	logic                     out_vld_q;
	logic                     out_found_q;
	logic [OW-1:0]            out_pos_q;

	assign s_tready = !out_vld_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign is_pat   = !s_tuser[0];
	assign is_ref   = s_tuser[0];
	assign first    = s_tuser[1];
	assign last     = s_tlast;

	always_comb begin
		ctrl.load  = acc && is_pat && (first || !act_chain[PATTERN_MAX-1]);
		ctrl.shift = acc && is_ref && !last;
		ctrl.clear = acc && (is_pat || last);
	end

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		fsms_pkg::sym_t pat_in;
		fsms_pkg::sym_t ref_in;
		logic           act_in;
		logic           rv_in;

		if (i == 0) begin : g_head
			assign pat_in = s_tdata;
			assign ref_in = s_tdata;
			assign act_in = 1'b1;
			assign rv_in  = 1'b1;
		end else begin : g_body
			assign pat_in = pat_chain[i-1];
			assign ref_in = ref_chain[i-1];
			assign act_in = act_chain[i-1] && !first;
			assign rv_in  = rv_chain[i-1];
		end

		fsms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.pat_in  (pat_in),
			.act_in  (act_in),
			.ref_in  (ref_in),
			.rv_in   (rv_in),
			.pat_out (pat_chain[i]),
			.act_out (act_chain[i]),
			.ref_out (ref_chain[i]),
			.rv_out  (rv_chain[i]),
			.hit     (hits[i])
		);
	end

	assign seen_nxt  = (seen_q == {POSITION_BITS{1'b1}}) ? seen_q
	                 : seen_q + POSITION_BITS'(1);
	assign match     = act_chain[0] && (&hits) && (CW'(seen_nxt) >= CW'(len_q));
	assign res_found = is_ref && !reported_q && match;
	assign res_none  = is_ref && last && !reported_q && !match;
	assign start     = CW'(seen_nxt) - CW'(len_q);
	assign start_ext = {{OW{1'b0}}, start};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (ctrl.load) begin
				len_q <= first ? LEN_W'(1) : len_q + LEN_W'(1);
			end
			if (ctrl.clear) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (ctrl.shift) begin
				seen_q <= seen_nxt;
				if (res_found) begin
					reported_q <= 1'b1;
				end
			end
			if (acc && (res_found || res_none)) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (res_found || res_none)) begin
			out_found_q <= res_found;
			out_pos_q   <= res_found ? start_ext[OW-1:0] : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_pos_q;
	assign m_tuser  = out_found_q;

	`include "assert_macros.svh"

	`FSMS_ASSERT_IMPL(a_none_pos_zero, m_tvalid && !m_tuser, m_tdata == '0)
	`FSMS_ASSERT(a_len_act, act_chain[0] == (len_q != '0))
	`FSMS_ASSERT_IMPL(a_reported_seen, reported_q, CW'(seen_q) >= CW'(len_q))
	`FSMS_ASSERT_NEXT(a_pat_restarts, acc && is_pat, !reported_q && (seen_q == '0))

endmodule
